// ===== rtl/qau_pkg.sv =====
package qau_pkg;

   localparam int FRAC_BITS = 16;
   localparam int WORD_BITS = 32;
   localparam int ACC_W     = 96;
   localparam int SCL_W     = 31;

   // operation codes on the request channel
   localparam logic [2:0] OP_MUL  = 3'd0;
   localparam logic [2:0] OP_CONJ = 3'd1;
   localparam logic [2:0] OP_INV  = 3'd2;
   localparam logic [2:0] OP_NORM = 3'd3;
   localparam logic [2:0] OP_ROT  = 3'd4;
   localparam logic [2:0] OP_SQ   = 3'd5;
   localparam logic [2:0] OP_MAG  = 3'd6;

   localparam logic signed [ACC_W-1:0] ACC_WMAX  = 96'sd2147483647;
   localparam logic signed [ACC_W-1:0] ACC_WMIN  = -96'sd2147483648;
   localparam logic signed [ACC_W-1:0] ACC_SMAX  = 96'sd2147483647;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = 96'sd1 <<< (FRAC_BITS - 1);
   localparam logic [WORD_BITS-1:0]   WORD_MAX  = 32'h7fff_ffff;
   localparam logic [WORD_BITS-1:0]   WORD_MIN  = 32'h8000_0000;
   localparam logic [SCL_W-1:0]       SCL_MAX   = 31'h7fff_ffff;

   // work class decided by the front end
   typedef enum logic [2:0] {
      K_HAM, K_CONJ, K_INV, K_NORM, K_ROT, K_SQ, K_MAG, K_NONE
   } kind_type;

   typedef struct packed {
      kind_type                   kind;
      logic [3:0][WORD_BITS-1:0]  a;
      logic [3:0][WORD_BITS-1:0]  b;
   } item_type;

   // one term of a hamilton product component
   typedef struct packed {
      logic       neg;
      logic [1:0] p;
      logic [1:0] q;
   } term_type;

   // component j (x,y,z,w) term k: sign, left index, right index
   function automatic term_type ham_term(input logic [3:0] jk);
      term_type t;
      t.p = jk[1:0] + 2'd3;
      t.neg = 1'b0;
      t.q = 2'd0;
      case (jk)
         4'h0: t.q = 2'd0;
         4'h1: t.q = 2'd3;
         4'h2: t.q = 2'd2;
         4'h3: begin t.q = 2'd1; t.neg = 1'b1; end
         4'h4: t.q = 2'd1;
         4'h5: begin t.q = 2'd2; t.neg = 1'b1; end
         4'h6: t.q = 2'd3;
         4'h7: t.q = 2'd0;
         4'h8: t.q = 2'd2;
         4'h9: t.q = 2'd1;
         4'ha: begin t.q = 2'd0; t.neg = 1'b1; end
         4'hb: t.q = 2'd3;
         4'hc: t.q = 2'd3;
         4'hd: begin t.q = 2'd0; t.neg = 1'b1; end
         4'he: begin t.q = 2'd1; t.neg = 1'b1; end
         4'hf: begin t.q = 2'd2; t.neg = 1'b1; end
         default: t.q = 2'd0;
      endcase
      return t;
   endfunction

   // round half up to the fraction width
   function automatic logic signed [ACC_W-1:0] round_frac(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] s;
      s = v + ROUND_HALF;
      return s >>> FRAC_BITS;
   endfunction

   // clamp to the signed word range, flag in the top bit
   function automatic logic [WORD_BITS:0] sat_word(input logic signed [ACC_W-1:0] v);
      logic [WORD_BITS:0] r;
      if (v > ACC_WMAX) r = {1'b1, WORD_MAX};
      else if (v < ACC_WMIN) r = {1'b1, WORD_MIN};
      else r = {1'b0, v[WORD_BITS-1:0]};
      return r;
   endfunction

endpackage

// ===== rtl/qau_queue.sv =====
module qau_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  qau_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output qau_pkg::item_type head
);

   qau_pkg::item_type slot_ff [2];
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        count_ff;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];

   // entry storage
   always_ff @(posedge clock) begin
      if (push && !full) slot_ff[wr_ptr_ff] <= push_item;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push && !full) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop && not_empty) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push && !full} - {1'b0, pop && not_empty};
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |=> count_ff != 2'd3) else $error("queue count out of range");
   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 && !push) |=> count_ff == 2'd0) else $error("queue underflow");
   a_both_keep: assert property (@(posedge clock) disable iff (reset)
      (push && !full && pop && not_empty) |=> $stable(count_ff))
      else $error("queue count drift");
`endif

endmodule

// ===== rtl/qau_front.sv =====
module qau_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [2:0]        op,
   input  logic [3:0][31:0]  a,
   input  logic [3:0][31:0]  b,
   output logic              push,
   output qau_pkg::item_type push_item,
   input  logic              q_full
);

   logic              hold_vld_ff;
   qau_pkg::item_type hold_ff;
   qau_pkg::kind_type kind;
   logic              take;

   // classify the operation code
   always_comb begin
      case (op)
         qau_pkg::OP_MUL:  kind = qau_pkg::K_HAM;
         qau_pkg::OP_CONJ: kind = qau_pkg::K_CONJ;
         qau_pkg::OP_INV:  kind = qau_pkg::K_INV;
         qau_pkg::OP_NORM: kind = qau_pkg::K_NORM;
         qau_pkg::OP_ROT:  kind = qau_pkg::K_ROT;
         qau_pkg::OP_SQ:   kind = qau_pkg::K_SQ;
         qau_pkg::OP_MAG:  kind = qau_pkg::K_MAG;
         default:          kind = qau_pkg::K_NONE;
      endcase
   end

   assign push      = hold_vld_ff && !q_full;
   assign busy      = hold_vld_ff && q_full;
   assign take      = start && !busy;
   assign push_item = hold_ff;

   // request holding register
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff <= 1'b0;
      end else if (take) begin
         hold_vld_ff <= 1'b1;
      end else if (push) begin
         hold_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         hold_ff.kind <= kind;
         hold_ff.a    <= a;
         hold_ff.b    <= b;
      end
   end

`ifndef SYNTHESIS
   a_hold_kept: assert property (@(posedge clock) disable iff (reset)
      busy |=> hold_vld_ff) else $error("held request lost while stalled");
   a_stall_stable: assert property (@(posedge clock) disable iff (reset)
      busy |=> $stable(hold_ff)) else $error("held request changed while stalled");
   a_take_loads: assert property (@(posedge clock) disable iff (reset)
      take |=> hold_vld_ff) else $error("accepted request not held");
`endif

endmodule

// ===== rtl/qau_back.sv =====
module qau_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  qau_pkg::item_type q_item,
   output logic              q_pop,
   output logic              rsp_strobe,
   output logic [31:0]       rsp_out_x,
   output logic [31:0]       rsp_out_y,
   output logic [31:0]       rsp_out_z,
   output logic [31:0]       rsp_out_w,
   output logic [30:0]       rsp_out_scalar,
   output logic              rsp_zero_magnitude,
   output logic              rsp_saturated
);

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_DRAIN, S_TRND, S_CLASS, S_SQRT, S_DIV, S_FIN
   } state_type;

   typedef enum logic [1:0] {P_HAM, P_ROT1, P_ROT2, P_SQ} phase_type;

   state_type                      state_ff;
   phase_type                      phase_ff;
   qau_pkg::item_type              item_ff;
   logic [4:0]                     step_ff;
   logic signed [65:0]             prod_ff;
   logic                           prod_vld_ff, prod_neg_ff, prod_sh_ff;
   logic [1:0]                     prod_tgt_ff;
   logic signed [95:0]             acc_ff [4];
   logic signed [51:0]             t_ff [4];
   logic [65:0]                    rad_ff;
   logic [35:0]                    rem_ff;
   logic [32:0]                    root_ff;
   logic [5:0]                     it_ff;
   logic [63:0]                    num_ff, quo_ff;
   logic [64:0]                    drem_ff, dvs_ff;
   logic [1:0]                     comp_ff;
   logic [31:0]                    res_ff [4];
   logic                           dsat_ff;
   logic                           strobe_ff, zero_ff, sat_ff;
   logic [31:0]                    ox_ff, oy_ff, oz_ff, ow_ff;
   logic [30:0]                    osc_ff;

   // multiplier operand selection
   logic [1:0]         tj, tk;
   logic               half;
   qau_pkg::term_type  tm;
   logic signed [32:0] mul_a, mul_b;
   logic               mul_neg, mul_last;
   logic [1:0]         mul_tgt;

   always_comb begin
      half = step_ff[0];
      if (phase_ff == P_ROT2) begin
         tj = step_ff[4:3];
         tk = step_ff[2:1];
      end else begin
         tj = step_ff[3:2];
         tk = step_ff[1:0];
      end
      tm = qau_pkg::ham_term({tj, tk});
      mul_tgt = tj;
      mul_neg = tm.neg;
      mul_last = (step_ff[3:0] == 4'hf);
      case (phase_ff)
         P_HAM: begin
            mul_a = {item_ff.a[tm.p][31], item_ff.a[tm.p]};
            mul_b = {item_ff.b[tm.q][31], item_ff.b[tm.q]};
         end
         P_ROT1: begin
            // v times conj(a), v has no scalar part
            mul_a = (tm.p == 2'd3) ? 33'sd0 : {item_ff.b[tm.p][31], item_ff.b[tm.p]};
            mul_b = {item_ff.a[tm.q][31], item_ff.a[tm.q]};
            mul_neg = tm.neg ^ (tm.q != 2'd3);
         end
         P_ROT2: begin
            mul_a = {item_ff.a[tm.p][31], item_ff.a[tm.p]};
            mul_b = half ? {{7{t_ff[tm.q][51]}}, t_ff[tm.q][51:26]}
                         : {7'b0, t_ff[tm.q][25:0]};
            mul_last = (step_ff == 5'd31);
         end
         default: begin
            mul_a = {item_ff.a[step_ff[1:0]][31], item_ff.a[step_ff[1:0]]};
            mul_b = mul_a;
            mul_neg = 1'b0;
            mul_tgt = 2'd0;
            mul_last = (step_ff[1:0] == 2'd3);
         end
      endcase
   end

   // accumulate addend
   logic signed [95:0] add_ext, add_val;
   always_comb begin
      add_ext = {{30{prod_ff[65]}}, prod_ff};
      if (prod_sh_ff) add_ext = add_ext <<< 26;
      add_val = prod_neg_ff ? -add_ext : add_ext;
   end

   // square root step, two radicand bits a cycle
   logic [35:0] rem_sh, trial, rem_in;
   logic        sq_ge;
   logic [32:0] root_in;
   always_comb begin
      rem_sh  = {rem_ff[33:0], rad_ff[65:64]};
      trial   = {1'b0, root_ff, 2'b01};
      sq_ge   = (rem_sh >= trial);
      rem_in  = sq_ge ? rem_sh - trial : rem_sh;
      root_in = {root_ff[31:0], sq_ge};
   end

   // restoring division step
   logic [65:0] rsh, rsub;
   logic        dge;
   logic [64:0] drem_in;
   logic [63:0] quo_in;
   always_comb begin
      rsh     = {drem_ff, num_ff[63]};
      rsub    = rsh - {1'b0, dvs_ff};
      dge     = (rsh >= {1'b0, dvs_ff});
      drem_in = dge ? rsub[64:0] : rsh[64:0];
      quo_in  = {quo_ff[62:0], dge};
   end

   function automatic logic comp_neg(input qau_pkg::kind_type k, input logic [31:0] av,
                                     input logic [1:0] idx);
      logic conj;
      conj = (k == qau_pkg::K_INV) && (idx != 2'd3);
      return conj ? (!av[31] && (av != 32'd0)) : av[31];
   endfunction

   // numerator load for the next component
   logic [1:0]  ncomp;
   logic [31:0] nav, nmag;
   logic [63:0] num_load;
   always_comb begin
      ncomp = (state_ff == S_DIV) ? comp_ff + 2'd1 : 2'd0;
      nav   = item_ff.a[ncomp];
      nmag  = nav[31] ? 32'd0 - nav : nav;
      num_load = (item_ff.kind == qau_pkg::K_INV) ? {nmag, 32'd0} : {16'd0, nmag, 16'd0};
   end

   // quotient clamp and sign
   logic        qneg, qsat;
   logic [31:0] qval;
   always_comb begin
      qneg = comp_neg(item_ff.kind, item_ff.a[comp_ff], comp_ff);
      qsat = 1'b0;
      if (!qneg) begin
         if (quo_in > {32'd0, qau_pkg::WORD_MAX}) begin
            qsat = 1'b1;
            qval = qau_pkg::WORD_MAX;
         end else begin
            qval = quo_in[31:0];
         end
      end else begin
         if (quo_in > {32'd0, qau_pkg::WORD_MIN}) begin
            qsat = 1'b1;
            qval = qau_pkg::WORD_MIN;
         end else begin
            qval = 32'd0 - quo_in[31:0];
         end
      end
   end

   // final result formation
   logic signed [95:0] acc_rnd [4];
   logic [32:0]        fs [4];
   logic signed [95:0] sq_r;
   logic [31:0]        fx, fy, fz, fw;
   logic [30:0]        fsc;
   logic               fzero, fsat;
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         acc_rnd[i] = qau_pkg::round_frac(acc_ff[i]);
         fs[i] = qau_pkg::sat_word(acc_rnd[i]);
      end
      sq_r  = acc_rnd[0];
      fx = 32'd0; fy = 32'd0; fz = 32'd0; fw = 32'd0;
      fsc = 31'd0; fzero = 1'b0; fsat = 1'b0;
      case (item_ff.kind)
         qau_pkg::K_HAM: begin
            fx = fs[0][31:0]; fy = fs[1][31:0]; fz = fs[2][31:0]; fw = fs[3][31:0];
            fsat = fs[0][32] | fs[1][32] | fs[2][32] | fs[3][32];
         end
         qau_pkg::K_ROT: begin
            fx = fs[0][31:0]; fy = fs[1][31:0]; fz = fs[2][31:0];
            fsat = fs[0][32] | fs[1][32] | fs[2][32];
         end
         qau_pkg::K_CONJ: begin
            fx = (item_ff.a[0] == qau_pkg::WORD_MIN) ? qau_pkg::WORD_MAX : 32'd0 - item_ff.a[0];
            fy = (item_ff.a[1] == qau_pkg::WORD_MIN) ? qau_pkg::WORD_MAX : 32'd0 - item_ff.a[1];
            fz = (item_ff.a[2] == qau_pkg::WORD_MIN) ? qau_pkg::WORD_MAX : 32'd0 - item_ff.a[2];
            fw = item_ff.a[3];
            fsat = (item_ff.a[0] == qau_pkg::WORD_MIN) | (item_ff.a[1] == qau_pkg::WORD_MIN)
                 | (item_ff.a[2] == qau_pkg::WORD_MIN);
         end
         qau_pkg::K_INV, qau_pkg::K_NORM: begin
            if (acc_ff[0] == 96'sd0) begin
               fx = item_ff.a[0]; fy = item_ff.a[1]; fz = item_ff.a[2]; fw = item_ff.a[3];
               fzero = 1'b1;
            end else begin
               fx = res_ff[0]; fy = res_ff[1]; fz = res_ff[2]; fw = res_ff[3];
               fsat = dsat_ff;
            end
         end
         qau_pkg::K_SQ: begin
            if (sq_r > qau_pkg::ACC_SMAX) begin
               fsc = qau_pkg::SCL_MAX;
               fsat = 1'b1;
            end else begin
               fsc = sq_r[30:0];
            end
         end
         qau_pkg::K_MAG: begin
            if (root_ff[32:31] != 2'b00) begin
               fsc = qau_pkg::SCL_MAX;
               fsat = 1'b1;
            end else begin
               fsc = root_ff[30:0];
            end
         end
         default: fsc = 31'd0;
      endcase
   end

   assign q_pop = (state_ff == S_IDLE) && q_valid;

   // multiplier pipeline and accumulators
   always_ff @(posedge clock) begin
      prod_ff     <= mul_a * mul_b;
      prod_neg_ff <= mul_neg;
      prod_sh_ff  <= (phase_ff == P_ROT2) && half;
      prod_tgt_ff <= mul_tgt;
      if (q_pop || state_ff == S_TRND) begin
         for (int i = 0; i < 4; i++) acc_ff[i] <= 96'sd0;
      end else if (prod_vld_ff) begin
         acc_ff[prod_tgt_ff] <= acc_ff[prod_tgt_ff] + add_val;
      end
   end

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         prod_vld_ff <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         prod_vld_ff <= (state_ff == S_MUL);
         strobe_ff   <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  item_ff <= q_item;
                  step_ff <= 5'd0;
                  case (q_item.kind)
                     qau_pkg::K_HAM: begin phase_ff <= P_HAM; state_ff <= S_MUL; end
                     qau_pkg::K_ROT: begin phase_ff <= P_ROT1; state_ff <= S_MUL; end
                     qau_pkg::K_INV, qau_pkg::K_NORM, qau_pkg::K_SQ, qau_pkg::K_MAG: begin
                        phase_ff <= P_SQ;
                        state_ff <= S_MUL;
                     end
                     default: state_ff <= S_FIN;
                  endcase
               end
            end
            S_MUL: begin
               step_ff <= step_ff + 5'd1;
               if (mul_last) state_ff <= S_DRAIN;
            end
            S_DRAIN: begin
               case (phase_ff)
                  P_ROT1:  state_ff <= S_TRND;
                  P_SQ:    state_ff <= S_CLASS;
                  default: state_ff <= S_FIN;
               endcase
            end
            S_TRND: begin
               for (int i = 0; i < 4; i++) t_ff[i] <= acc_rnd[i][51:0];
               phase_ff <= P_ROT2;
               step_ff  <= 5'd0;
               state_ff <= S_MUL;
            end
            S_CLASS: begin
               rad_ff  <= {1'b0, acc_ff[0][64:0]};
               rem_ff  <= 36'd0;
               root_ff <= 33'd0;
               it_ff   <= 6'd0;
               num_ff  <= num_load;
               drem_ff <= 65'd0;
               quo_ff  <= 64'd0;
               dvs_ff  <= acc_ff[0][64:0];
               comp_ff <= 2'd0;
               dsat_ff <= 1'b0;
               if (item_ff.kind == qau_pkg::K_SQ || acc_ff[0] == 96'sd0) begin
                  state_ff <= S_FIN;
               end else if (item_ff.kind == qau_pkg::K_INV) begin
                  state_ff <= S_DIV;
               end else begin
                  state_ff <= S_SQRT;
               end
            end
            S_SQRT: begin
               rad_ff  <= {rad_ff[63:0], 2'b00};
               rem_ff  <= rem_in;
               root_ff <= root_in;
               it_ff   <= it_ff + 6'd1;
               if (it_ff == 6'd32) begin
                  // divider count starts over for the first component
                  it_ff  <= 6'd0;
                  dvs_ff <= {32'd0, root_in};
                  state_ff <= (item_ff.kind == qau_pkg::K_NORM) ? S_DIV : S_FIN;
               end
            end
            S_DIV: begin
               num_ff  <= {num_ff[62:0], 1'b0};
               drem_ff <= drem_in;
               quo_ff  <= quo_in;
               it_ff   <= it_ff + 6'd1;
               if (it_ff == 6'd63) begin
                  res_ff[comp_ff] <= qval;
                  dsat_ff <= dsat_ff | qsat;
                  comp_ff <= comp_ff + 2'd1;
                  num_ff  <= num_load;
                  drem_ff <= 65'd0;
                  quo_ff  <= 64'd0;
                  if (comp_ff == 2'd3) state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               ox_ff     <= fx;
               oy_ff     <= fy;
               oz_ff     <= fz;
               ow_ff     <= fw;
               osc_ff    <= fsc;
               zero_ff   <= fzero;
               sat_ff    <= fsat;
               strobe_ff <= 1'b1;
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_out_x          = ox_ff;
   assign rsp_out_y          = oy_ff;
   assign rsp_out_z          = oz_ff;
   assign rsp_out_w          = ow_ff;
   assign rsp_out_scalar     = osc_ff;
   assign rsp_zero_magnitude = zero_ff;
   assign rsp_saturated      = sat_ff;

`ifndef SYNTHESIS
   a_strobe_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(strobe_ff) |-> $past(state_ff == S_FIN)) else $error("result without finish");
   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff != S_IDLE) else $error("popped item not started");
   a_zero_no_sat: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && zero_ff) |-> !sat_ff) else $error("pass-through flagged as clamped");
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |=> !strobe_ff) else $error("result repeated");
`endif

endmodule

// ===== rtl/quaternion_arithmetic_unit.sv =====
// channel    ports                         transfer
// request    start, busy, req_*            start high while busy low
// result     rsp_strobe, rsp_*             one cycle per result, no back-pressure
//
// in the back end, multiply, rotate, square magnitude, magnitude, inverse
// and normalize share one 33x33 multiplier; magnitude and normalize
// then use a 2-bit-a-cycle square root, and inverse and normalize a
// 1-bit-a-cycle divider. conjugate and undefined codes skip all three.
// the front end takes a new request while the back end works, until the
// two-entry queue and the holding register are full; busy shows that.
// reset is synchronous and clears only control state.
module quaternion_arithmetic_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_operation,
   input  logic [31:0] req_a_x,
   input  logic [31:0] req_a_y,
   input  logic [31:0] req_a_z,
   input  logic [31:0] req_a_w,
   input  logic [31:0] req_b_x,
   input  logic [31:0] req_b_y,
   input  logic [31:0] req_b_z,
   input  logic [31:0] req_b_w,
   output logic        rsp_strobe,
   output logic [31:0] rsp_out_x,
   output logic [31:0] rsp_out_y,
   output logic [31:0] rsp_out_z,
   output logic [31:0] rsp_out_w,
   output logic [30:0] rsp_out_scalar,
   output logic        rsp_zero_magnitude,
   output logic        rsp_saturated
);

   logic              push, q_full, q_pop, q_valid;
   qau_pkg::item_type push_item, head;

   qau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .op        (req_operation),
      .a         ({req_a_w, req_a_z, req_a_y, req_a_x}),
      .b         ({req_b_w, req_b_z, req_b_y, req_b_x}),
      .push      (push),
      .push_item (push_item),
      .q_full    (q_full)
   );

   qau_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head      (head)
   );

   qau_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_item             (head),
      .q_pop              (q_pop),
      .rsp_strobe         (rsp_strobe),
      .rsp_out_x          (rsp_out_x),
      .rsp_out_y          (rsp_out_y),
      .rsp_out_z          (rsp_out_z),
      .rsp_out_w          (rsp_out_w),
      .rsp_out_scalar     (rsp_out_scalar),
      .rsp_zero_magnitude (rsp_zero_magnitude),
      .rsp_saturated      (rsp_saturated)
   );

endmodule

// ===== tb/tb_quaternion_arithmetic_unit.sv =====
module tb_quaternion_arithmetic_unit;

   localparam logic [2:0] OP_UNDEF = 3'd7;
   localparam int IDLE_LIMIT = 4000;

   typedef logic signed [127:0] wide_type;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] w;
      logic [30:0] scalar;
      logic        zero_mag;
      logic        sat;
   } quat_result_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_operation;
   logic [31:0] req_a_x, req_a_y, req_a_z, req_a_w;
   logic [31:0] req_b_x, req_b_y, req_b_z, req_b_w;
   logic        rsp_strobe;
   logic [31:0] rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w;
   logic [30:0] rsp_out_scalar;
   logic        rsp_zero_magnitude;
   logic        rsp_saturated;

   quat_result_type pending_results[$];
   int              error_count = 0;
   int              idle_cycles = 0;
   int              burst_left  = 0;

   quaternion_arithmetic_unit DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation),
      .req_a_x(req_a_x), .req_a_y(req_a_y), .req_a_z(req_a_z), .req_a_w(req_a_w),
      .req_b_x(req_b_x), .req_b_y(req_b_y), .req_b_z(req_b_z), .req_b_w(req_b_w),
      .rsp_strobe(rsp_strobe),
      .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y), .rsp_out_z(rsp_out_z),
      .rsp_out_w(rsp_out_w), .rsp_out_scalar(rsp_out_scalar),
      .rsp_zero_magnitude(rsp_zero_magnitude), .rsp_saturated(rsp_saturated)
   );

   // clock generation
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // ---------------- predictor ----------------

   function automatic wide_type ext32(input logic [31:0] v);
      return wide_type'(signed'(v));
   endfunction

   function automatic wide_type round_q(input wide_type v);
      return (v + (wide_type'(1) <<< (qau_pkg::FRAC_BITS - 1))) >>> qau_pkg::FRAC_BITS;
   endfunction

   function automatic logic [31:0] clamp_word(input wide_type v, inout logic flag);
      if (v > wide_type'(2147483647)) begin
         flag = 1'b1;
         return qau_pkg::WORD_MAX;
      end
      if (v < -(wide_type'(1) <<< 31)) begin
         flag = 1'b1;
         return qau_pkg::WORD_MIN;
      end
      return v[31:0];
   endfunction

   // exact hamilton product p*q, order x, y, z, w
   function automatic void hamilton_exact(input wide_type p[4], input wide_type q[4],
                                          output wide_type r[4]);
      r[0] = p[3]*q[0] + p[0]*q[3] + p[1]*q[2] - p[2]*q[1];
      r[1] = p[3]*q[1] - p[0]*q[2] + p[1]*q[3] + p[2]*q[0];
      r[2] = p[3]*q[2] + p[0]*q[1] - p[1]*q[0] + p[2]*q[3];
      r[3] = p[3]*q[3] - p[0]*q[0] - p[1]*q[1] - p[2]*q[2];
   endfunction

   function automatic logic [127:0] floor_sqrt(input logic [127:0] s);
      logic [127:0] r;
      logic [127:0] c;
      r = '0;
      for (int i = 33; i >= 0; i--) begin
         c = r | (128'd1 << i);
         if (c * c <= s) r = c;
      end
      return r;
   endfunction

   // signed c * 2^sh / d truncated toward zero, then clamped
   function automatic logic [31:0] scaled_quotient(input wide_type c, input int sh,
                                                   input logic [127:0] d,
                                                   inout logic flag);
      logic [127:0] mag;
      logic [127:0] q;
      mag = (c < 0) ? -c : c;
      q = (mag << sh) / d;
      return clamp_word((c < 0) ? -wide_type'(q) : wide_type'(q), flag);
   endfunction

   function automatic quat_result_type predict_quat(input logic [2:0] op,
                                                    input logic [31:0] ar[4],
                                                    input logic [31:0] br[4]);
      quat_result_type res;
      wide_type a[4], b[4], v[4], c[4], t[4], p[4];
      wide_type s, r;
      logic [127:0] m;
      logic sat;
      res = '0;
      sat = 1'b0;
      for (int i = 0; i < 4; i++) begin
         a[i] = ext32(ar[i]);
         b[i] = ext32(br[i]);
      end
      s = a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3];
      case (op)
         qau_pkg::OP_MUL: begin
            hamilton_exact(a, b, p);
            res.x = clamp_word(round_q(p[0]), sat);
            res.y = clamp_word(round_q(p[1]), sat);
            res.z = clamp_word(round_q(p[2]), sat);
            res.w = clamp_word(round_q(p[3]), sat);
         end
         qau_pkg::OP_CONJ: begin
            res.x = clamp_word(-a[0], sat);
            res.y = clamp_word(-a[1], sat);
            res.z = clamp_word(-a[2], sat);
            res.w = clamp_word(a[3], sat);
         end
         qau_pkg::OP_INV, qau_pkg::OP_NORM: begin
            if (s == 0) begin
               // zero magnitude passes a through
               res.zero_mag = 1'b1;
               res.x = ar[0];
               res.y = ar[1];
               res.z = ar[2];
               res.w = ar[3];
            end else if (op == qau_pkg::OP_INV) begin
               res.x = scaled_quotient(-a[0], 2*qau_pkg::FRAC_BITS, s, sat);
               res.y = scaled_quotient(-a[1], 2*qau_pkg::FRAC_BITS, s, sat);
               res.z = scaled_quotient(-a[2], 2*qau_pkg::FRAC_BITS, s, sat);
               res.w = scaled_quotient(a[3], 2*qau_pkg::FRAC_BITS, s, sat);
            end else begin
               m = floor_sqrt(s);
               res.x = scaled_quotient(a[0], qau_pkg::FRAC_BITS, m, sat);
               res.y = scaled_quotient(a[1], qau_pkg::FRAC_BITS, m, sat);
               res.z = scaled_quotient(a[2], qau_pkg::FRAC_BITS, m, sat);
               res.w = scaled_quotient(a[3], qau_pkg::FRAC_BITS, m, sat);
            end
         end
         qau_pkg::OP_ROT: begin
            // t = v * conj(a), rounded to 64 bits, then a * t
            for (int i = 0; i < 3; i++) begin
               v[i] = b[i];
               c[i] = -a[i];
            end
            v[3] = 0;
            c[3] = a[3];
            hamilton_exact(v, c, p);
            for (int i = 0; i < 4; i++) begin
               r = round_q(p[i]);
               t[i] = wide_type'(signed'(r[63:0]));
            end
            hamilton_exact(a, t, p);
            res.x = clamp_word(round_q(p[0]), sat);
            res.y = clamp_word(round_q(p[1]), sat);
            res.z = clamp_word(round_q(p[2]), sat);
         end
         qau_pkg::OP_SQ: begin
            r = round_q(s);
            if (r > wide_type'(qau_pkg::SCL_MAX)) begin
               sat = 1'b1;
               res.scalar = qau_pkg::SCL_MAX;
            end else begin
               res.scalar = r[30:0];
            end
         end
         qau_pkg::OP_MAG: begin
            m = floor_sqrt(s);
            if (m > 128'(qau_pkg::SCL_MAX)) begin
               sat = 1'b1;
               res.scalar = qau_pkg::SCL_MAX;
            end else begin
               res.scalar = m[30:0];
            end
         end
         default: res = '0;
      endcase
      res.sat = sat;
      return res;
   endfunction

   // ---------------- stimulus ----------------

   // send one request, with bursts and random gaps on the sender side
   task automatic send_quat(input logic [2:0] op, input logic [31:0] ar[4],
                            input logic [31:0] br[4]);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 20);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start <= 1'b1;
      req_operation <= op;
      req_a_x <= ar[0]; req_a_y <= ar[1]; req_a_z <= ar[2]; req_a_w <= ar[3];
      req_b_x <= br[0]; req_b_y <= br[1]; req_b_z <= br[2]; req_b_w <= br[3];
      do @(posedge clock); while (busy);
      pending_results.push_back(predict_quat(op, ar, br));
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return $urandom_range(0, 3) == 0 ? 32'h0001_0000 : 32'hffff_0000;
         4, 5: return 32'($signed($urandom_range(0, 262143)) - 131072);
         default: return $urandom;
      endcase
   endfunction

   task automatic test_extremes();
      logic [31:0] ar[4], br[4];
      logic [31:0] corner[4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
      // every code on all-minimum and all-maximum; inverse, normalize and magnitude also on zero and minus one lsb
      for (int k = 0; k < 4; k++) begin
         for (int o = 0; o < 8; o++) begin
            if (k >= 2 && o != qau_pkg::OP_INV && o != qau_pkg::OP_NORM
                && o != qau_pkg::OP_MAG) continue;
            for (int i = 0; i < 4; i++) begin
               ar[i] = corner[k];
               br[i] = corner[3 - k];
            end
            send_quat(3'(o), ar, br);
         end
      end
   endtask

   task automatic test_special_cases();
      logic [31:0] ar[4], br[4];
      // conjugate of the most negative value
      ar = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h1};
      br = '{32'h0, 32'h0, 32'h0, 32'h0};
      send_quat(qau_pkg::OP_CONJ, ar, br);
      // identity rotation and unit quaternion inverse and normalize
      ar = '{32'h0, 32'h0, 32'h0, 32'h0001_0000};
      br = '{32'h0003_0000, 32'hfffe_0000, 32'h0001_8000, 32'h1234_5678};
      send_quat(qau_pkg::OP_ROT, ar, br);
      send_quat(qau_pkg::OP_INV, ar, br);
      send_quat(qau_pkg::OP_NORM, ar, br);
      // undefined code with random payload
      ar = '{$urandom, $urandom, $urandom, $urandom};
      send_quat(OP_UNDEF, ar, br);
   endtask

   task automatic test_random(input int count);
      logic [31:0] ar[4], br[4];
      logic [2:0] op;
      for (int n = 0; n < count; n++) begin
         op = 3'($urandom_range(0, 7));
         for (int i = 0; i < 4; i++) begin
            ar[i] = pick_value();
            br[i] = pick_value();
         end
         // zero magnitude now and then for inverse and normalize
         if ((op == qau_pkg::OP_INV || op == qau_pkg::OP_NORM) && $urandom_range(0, 5) == 0)
            ar = '{32'h0, 32'h0, 32'h0, 32'h0};
         send_quat(op, ar, br);
      end
   endtask

   // ---------------- checking ----------------

   // compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      quat_result_type got, want;
      if (!reset && rsp_strobe) begin
         got = '{rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w, rsp_out_scalar,
                 rsp_zero_magnitude, rsp_saturated};
         if (pending_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result x=%h y=%h z=%h w=%h s=%h zm=%b sat=%b",
                     $time, got.x, got.y, got.z, got.w, got.scalar,
                     got.zero_mag, got.sat);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               error_count++;
               $display("%0t: mismatch expected x=%h y=%h z=%h w=%h s=%h zm=%b sat=%b",
                        $time, want.x, want.y, want.z, want.w, want.scalar,
                        want.zero_mag, want.sat);
               $display("%0t:          actual   x=%h y=%h z=%h w=%h s=%h zm=%b sat=%b",
                        $time, got.x, got.y, got.z, got.w, got.scalar,
                        got.zero_mag, got.sat);
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_quaternion_arithmetic_unit: FAIL");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_operation = qau_pkg::OP_MUL;
      {req_a_x, req_a_y, req_a_z, req_a_w} = '0;
      {req_b_x, req_b_y, req_b_z, req_b_w} = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_special_cases();
      test_random(600);
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_quaternion_arithmetic_unit: PASS");
      end else begin
         $display("tb_quaternion_arithmetic_unit: FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/qau_pkg.sv
rtl/qau_queue.sv
rtl/qau_front.sv
rtl/qau_back.sv
rtl/quaternion_arithmetic_unit.sv
tb/tb_quaternion_arithmetic_unit.sv
